>>> rtl/lbc_pkg.sv
`default_nettype none

package lbc_pkg;

  localparam int unsigned KEY_BITS  = 64;
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned OCC_BITS  = 5;
  localparam int unsigned CAP_BITS  = 5;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_GET      = 2'd0,
    OP_INSERT   = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_CLEAR    = 2'd3
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [KEY_BITS-1:0]  block_index;
    logic [WORD_BITS-1:0] payload;
  } item_t;

  typedef struct packed {
    logic                 hit;
    logic [WORD_BITS-1:0] data_out;
    logic [OCC_BITS-1:0]  occupancy;
  } result_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic is_clear;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/lbc_ctrl.sv
`default_nettype none

module lbc_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  output logic             busy_o,
  output logic             done_o,
  input  lbc_pkg::status_t status_i,
  output lbc_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_WAIT   = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status_i.is_clear || status_i.scan_last) begin
          state_d = status_i.is_clear ? S_COMMIT : S_WAIT;
        end
      end
      S_WAIT:   state_d = S_COMMIT;
      S_COMMIT: state_d = S_RESP;
      S_RESP:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = (state_q == S_RESP);
  assign cmd_o.load    = (state_q == S_IDLE) && start_i;
  assign cmd_o.scan    = (state_q == S_SCAN) && !status_i.is_clear;
  assign cmd_o.commit  = (state_q == S_COMMIT);

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_SCAN)
    else $error("accepted word did not start a scan");

  a_resp_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == S_COMMIT)
    else $error("result without commit");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o && !cmd_o.load)
    else $error("result while idle");

endmodule

`default_nettype wire

>>> rtl/lbc_datapath.sv
`default_nettype none

module lbc_datapath #(
  parameter int unsigned ENTRIES      = 16,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  lbc_pkg::item_t                     item_i,
  input  wire                                cfg_we_i,
  input  wire  [lbc_pkg::CAP_BITS-1:0]       cfg_wdata_i,
  input  lbc_pkg::cmd_t                      cmd_i,
  output lbc_pkg::status_t                   status_o,
  output lbc_pkg::result_t                   result_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned AW = IW;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned XW = (CW > lbc_pkg::CAP_BITS) ? CW : lbc_pkg::CAP_BITS;

  logic [lbc_pkg::KEY_BITS-1:0] key_mem [ENTRIES];
  logic [PAYLOAD_BITS-1:0]      pay_mem [ENTRIES];

  lbc_pkg::op_e                 op_q;
  logic [lbc_pkg::KEY_BITS-1:0] key_q;
  logic [PAYLOAD_BITS-1:0]      pay_q;
  logic [IW-1:0]                addr_q;
  logic                         cmp_vld_q;
  logic [IW-1:0]                cmp_idx_q;
  logic [lbc_pkg::KEY_BITS-1:0] key_rd_q;
  logic                         hit_q;
  logic [IW-1:0]                hit_idx_q;
  logic                         free_q;
  logic [IW-1:0]                free_idx_q;
  logic [IW-1:0]                victim_idx_q;
  logic [PAYLOAD_BITS-1:0]      pay_rd_q;
  logic [lbc_pkg::CAP_BITS-1:0] cap_q;

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [AW-1:0]      age_q [ENTRIES];
  logic [AW-1:0]      age_d [ENTRIES];
  logic [CW-1:0]      count_q, count_d;

  logic          evict;
  logic [IW-1:0] slot;
  logic [AW-1:0] touch_age;
  logic [AW-1:0] oldest_age;

  assign oldest_age = AW'(count_q - 1'b1);
  assign touch_age  = age_q[hit_idx_q];
  assign evict      = (count_q != '0) &&
                      ((cap_q == '0) || (XW'(count_q) >= XW'(cap_q)) ||
                       (count_q == CW'(ENTRIES)));
  assign slot       = (evict && !(free_q && (free_idx_q < victim_idx_q))) ?
                      victim_idx_q : free_idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= lbc_pkg::op_e'(item_i.op);
      key_q <= item_i.block_index;
      pay_q <= item_i.payload[PAYLOAD_BITS-1:0];
    end
    if (cmd_i.scan) begin
      key_rd_q  <= key_mem[addr_q];
      cmp_idx_q <= addr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && (op_q == lbc_pkg::OP_INSERT)) begin
      if (!hit_q) begin
        key_mem[slot] <= key_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      pay_rd_q <= pay_mem[hit_idx_q];
      if (op_q == lbc_pkg::OP_INSERT) begin
        pay_mem[hit_q ? hit_idx_q : slot] <= pay_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      cap_q     <= lbc_pkg::CAP_RESET;
    end else begin
      cmp_vld_q <= cmd_i.scan;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        addr_q <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (cmd_i.scan) begin
          addr_q <= addr_q + 1'b1;
        end
        if (cmp_vld_q) begin
          if (valid_q[cmp_idx_q] && (key_rd_q == key_q) && !hit_q) begin
            hit_q <= 1'b1;
          end
          if (!valid_q[cmp_idx_q] && !free_q) begin
            free_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_vld_q) begin
      if (valid_q[cmp_idx_q] && (key_rd_q == key_q) && !hit_q) begin
        hit_idx_q <= cmp_idx_q;
      end
      if (!valid_q[cmp_idx_q] && !free_q) begin
        free_idx_q <= cmp_idx_q;
      end
      if (valid_q[cmp_idx_q] && (age_q[cmp_idx_q] == oldest_age)) begin
        victim_idx_q <= cmp_idx_q;
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    age_d   = age_q;
    count_d = count_q;
    if (cmd_i.commit) begin
      unique case (op_q)
        lbc_pkg::OP_CLEAR: begin
          valid_d = '0;
          for (int j = 0; j < ENTRIES; j++) begin
            age_d[j] = '0;
          end
          count_d = '0;
        end
        lbc_pkg::OP_GET, lbc_pkg::OP_INSERT: begin
          if (hit_q) begin
            for (int j = 0; j < ENTRIES; j++) begin
              if (valid_q[j] && (age_q[j] < touch_age)) begin
                age_d[j] = age_q[j] + 1'b1;
              end
            end
            age_d[hit_idx_q] = '0;
          end else if (op_q == lbc_pkg::OP_INSERT) begin
            for (int j = 0; j < ENTRIES; j++) begin
              if (valid_q[j]) begin
                age_d[j] = age_q[j] + 1'b1;
              end
            end
            if (evict) begin
              valid_d[victim_idx_q] = 1'b0;
              age_d[victim_idx_q]   = '0;
            end
            valid_d[slot] = 1'b1;
            age_d[slot]   = '0;
            count_d       = evict ? count_q : count_q + 1'b1;
          end
        end
        lbc_pkg::OP_CONTAINS: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int j = 0; j < ENTRIES; j++) begin
        age_q[j] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      age_q   <= age_d;
    end
  end

  assign status_o.scan_last = (addr_q == IW'(ENTRIES - 1));
  assign status_o.is_clear  = (op_q == lbc_pkg::OP_CLEAR);

  always_comb begin
    result_o.hit       = hit_q;
    result_o.data_out  = ((op_q == lbc_pkg::OP_GET) && hit_q) ?
                         lbc_pkg::WORD_BITS'(pay_rd_q) : '0;
    result_o.occupancy = lbc_pkg::OCC_BITS'(count_q);
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ENTRIES))
    else $error("occupancy above table size");

  a_count_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("occupancy does not match valid entries");

  a_cmp_follows_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |=> cmp_vld_q && (cmp_idx_q == $past(addr_q)))
    else $error("compare stage out of step with scan");

endmodule

`default_nettype wire

>>> rtl/lru_block_cache_core.sv
`default_nettype none

// Fully associative LRU cache of ENTRIES keys, 64-bit key, PAYLOAD_BITS-bit data word.
// A word is taken when start is high and busy is low; its result shows on result_o
// for exactly one cycle with done_o high and cannot be held off. For get, insert and
// contains the next word is taken only after the result: the key memory has one read
// port, so the search walks it one entry per cycle, then S_WAIT drains the compare,
// S_COMMIT applies the update and reads the data word, S_RESP presents the result.
// Clear skips the walk and S_WAIT. The user must write capacity (cfg_we_i/cfg_wdata_i)
// while busy is low (not enforced); 0 acts as 1, values above ENTRIES as ENTRIES.
module lru_block_cache_core #(
  parameter int unsigned ENTRIES      = 16,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  lbc_pkg::item_t               item_i,
  output logic                         done_o,
  output lbc_pkg::result_t             result_o,
  input  wire                          cfg_we_i,
  input  wire  [lbc_pkg::CAP_BITS-1:0] cfg_wdata_i
);

  lbc_pkg::cmd_t    cmd;
  lbc_pkg::status_t status;

  lbc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .done_o   (done_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  lbc_datapath #(
    .ENTRIES      (ENTRIES),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire
